/* src/ybl_pkg.sv */
// shared types and constants for the yellow band locator
package ybl_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CFG_W = 13;
   localparam int OUT_W = 12;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   localparam logic [7:0] YELLOW_FULL  = 8'd255;
   localparam logic [7:0] YELLOW_EMPTY = 8'd0;

   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] plate_x;
      logic [OUT_W-1:0] plate_y;
   } rsp_type;

   typedef struct packed {
      logic    frame_done;
      rsp_type result;
   } scan_status_type;

endpackage

/* src/ybl_scan.sv */
// per-row yellow counting and run tracking, one pixel per step
module ybl_scan import ybl_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           yellow,
   input  logic [$clog2(MAX_DIM+1)-1:0]   width,
   input  logic [$clog2(MAX_DIM+1)-1:0]   height,
   output scan_status_type                status
);

   localparam int PW = $clog2(MAX_DIM);
   localparam int CW = $clog2(MAX_DIM + 1);

   logic [PW-1:0] column_pos_ff, column_pos_in;
   logic [PW-1:0] row_pos_ff, row_pos_in;
   logic [CW-1:0] row_yellow_count_ff, row_yellow_count_in;
   logic [CW-1:0] best_row_count_ff, best_row_count_in;
   logic [PW-1:0] best_row_index_ff, best_row_index_in;
   logic [CW-1:0] run_length_ff, run_length_in;
   logic [PW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] row_best_run_length_ff, row_best_run_length_in;
   logic [PW-1:0] row_best_run_start_ff, row_best_run_start_in;
   logic [PW-1:0] best_column_ff, best_column_in;

   logic [CW-1:0] count_upd;
   logic [CW-1:0] run_len_upd;
   logic [PW-1:0] run_start_upd;
   logic [CW-1:0] row_best_len_upd;
   logic [PW-1:0] row_best_start_upd;
   logic [CW-1:0] best_cnt_upd;
   logic [PW-1:0] best_row_upd;
   logic [PW-1:0] best_col_upd;
   logic [CW:0]   col_next_wide;
   logic [CW:0]   row_next_wide;
   logic          row_end;
   logic          frame_end;

   always_comb begin
      // run and count update for this pixel
      count_upd          = row_yellow_count_ff;
      run_len_upd        = run_length_ff;
      run_start_upd      = run_start_ff;
      row_best_len_upd   = row_best_run_length_ff;
      row_best_start_upd = row_best_run_start_ff;
      if (yellow) begin
         if (run_length_ff == '0) begin
            run_start_upd = column_pos_ff;
         end
         run_len_upd = run_length_ff + 1'b1;
         count_upd   = row_yellow_count_ff + 1'b1;
      end else begin
         // a non-yellow pixel closes the run
         if (run_length_ff > row_best_run_length_ff) begin
            row_best_len_upd   = run_length_ff;
            row_best_start_upd = run_start_ff;
         end
         run_len_upd = '0;
      end

      col_next_wide = (CW+1)'(column_pos_ff) + 1'b1;
      row_next_wide = (CW+1)'(row_pos_ff) + 1'b1;
      row_end       = col_next_wide >= (CW+1)'(width);
      frame_end     = row_end && (row_next_wide >= (CW+1)'(height));

      best_cnt_upd = best_row_count_ff;
      best_row_upd = best_row_index_ff;
      best_col_upd = best_column_ff;
      if (row_end && (count_upd > best_row_count_ff)) begin
         best_cnt_upd = count_upd;
         best_row_upd = row_pos_ff;
         best_col_upd = row_best_start_upd;
      end

      column_pos_in          = column_pos_ff;
      row_pos_in             = row_pos_ff;
      row_yellow_count_in    = row_yellow_count_ff;
      best_row_count_in      = best_row_count_ff;
      best_row_index_in      = best_row_index_ff;
      run_length_in          = run_length_ff;
      run_start_in           = run_start_ff;
      row_best_run_length_in = row_best_run_length_ff;
      row_best_run_start_in  = row_best_run_start_ff;
      best_column_in         = best_column_ff;

      if (step) begin
         if (!row_end) begin
            column_pos_in          = column_pos_ff + 1'b1;
            row_yellow_count_in    = count_upd;
            run_length_in          = run_len_upd;
            run_start_in           = run_start_upd;
            row_best_run_length_in = row_best_len_upd;
            row_best_run_start_in  = row_best_start_upd;
         end else begin
            // open run at the row end is dropped
            column_pos_in          = '0;
            row_yellow_count_in    = '0;
            run_length_in          = '0;
            run_start_in           = '0;
            row_best_run_length_in = '0;
            row_best_run_start_in  = '0;
            if (!frame_end) begin
               row_pos_in        = row_pos_ff + 1'b1;
               best_row_count_in = best_cnt_upd;
               best_row_index_in = best_row_upd;
               best_column_in    = best_col_upd;
            end else begin
               row_pos_in        = '0;
               best_row_count_in = '0;
               best_row_index_in = '0;
               best_column_in    = '0;
            end
         end
      end

      status.frame_done     = step && frame_end;
      status.result.plate_x = OUT_W'(best_col_upd);
      status.result.plate_y = OUT_W'(best_row_upd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff          <= '0;
         row_pos_ff             <= '0;
         row_yellow_count_ff    <= '0;
         best_row_count_ff      <= '0;
         best_row_index_ff      <= '0;
         run_length_ff          <= '0;
         run_start_ff           <= '0;
         row_best_run_length_ff <= '0;
         row_best_run_start_ff  <= '0;
         best_column_ff         <= '0;
      end else begin
         column_pos_ff          <= column_pos_in;
         row_pos_ff             <= row_pos_in;
         row_yellow_count_ff    <= row_yellow_count_in;
         best_row_count_ff      <= best_row_count_in;
         best_row_index_ff      <= best_row_index_in;
         run_length_ff          <= run_length_in;
         run_start_ff           <= run_start_in;
         row_best_run_length_ff <= row_best_run_length_in;
         row_best_run_start_ff  <= row_best_run_start_in;
         best_column_ff         <= best_column_in;
      end
   end

endmodule

/* src/yellow_band_locator.sv */
// Yellow band locator: takes one pixel word per clock in raster order and, from the
// clock edge at which the last pixel of a frame leaves the input register, gives one
// result word with the column where the longest closed yellow run of the most
// yellow row begins and that row (both zero when the frame holds no yellow).
// A pixel is yellow when its bytes are 255, 255, 0. Frame size comes from two
// registers, image_width (index 0) and image_height (index 1); zero reads as 1
// and values above MAX_DIM saturate. Sustained rate is one pixel per clock while
// results are taken, set by the combinational row and run update; the last
// pixel passes the input register and then the result register. Input is held
// off only while a result waits on the output and the input register is occupied.
module yellow_band_locator import ybl_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int DW = $clog2(MAX_DIM + 1);

   logic [DW-1:0]   width_ff, width_in;
   logic [DW-1:0]   height_ff, height_in;
   logic [DW-1:0]   csr_clamped;
   logic [31:0]     csr_wide;

   logic            pix_valid_ff, pix_valid_in;
   logic            pix_yellow_ff, pix_yellow_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            advance;
   logic            step;
   scan_status_type scan_status;

   // register writes, clamped on the way in
   always_comb begin
      csr_wide = 32'(csr_wdata);
      if (csr_wide == 32'd0) begin
         csr_clamped = DW'(1);
      end else if (csr_wide > 32'(MAX_DIM)) begin
         csr_clamped = DW'(MAX_DIM);
      end else begin
         csr_clamped = DW'(csr_wide);
      end
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_clamped;
            CSR_IMAGE_HEIGHT: height_in = csr_clamped;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // input register: pixel classified on entry
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pix_valid_ff || advance;
   assign step      = pix_valid_ff && advance;

   always_comb begin
      pix_valid_in  = pix_valid_ff;
      pix_yellow_in = pix_yellow_ff;
      if (req_ready) begin
         pix_valid_in  = req_valid;
         pix_yellow_in = (req_data.chan0 == YELLOW_FULL) &&
                         (req_data.chan1 == YELLOW_FULL) &&
                         (req_data.chan2 == YELLOW_EMPTY);
      end
   end

   ybl_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .yellow (pix_yellow_ff),
      .width  (width_ff),
      .height (height_ff),
      .status (scan_status)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_status.frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = scan_status.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DW'(IMAGE_WIDTH_RESET);
         height_ff    <= DW'(IMAGE_HEIGHT_RESET);
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_yellow_ff <= pix_yellow_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a frame end never lands on a result word that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      scan_status.frame_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("frame result would overwrite a pending word");

   // a stalled pixel stays in the input register untouched
   assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && !advance) |=> (pix_valid_ff && $stable(pix_yellow_ff)))
      else $error("stalled pixel lost or changed");

   // an accepted pixel always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> pix_valid_ff)
      else $error("accepted pixel not captured");

   // frame size registers stay within the clamped range
   assert property (@(posedge clock) disable iff (reset)
      (width_ff != '0) && (height_ff != '0) &&
      (32'(width_ff) <= 32'(MAX_DIM)) && (32'(height_ff) <= 32'(MAX_DIM)))
      else $error("frame size register out of range");

endmodule

/* bench/yellow_band_locator_tb.sv */
// self-checking testbench for the yellow band locator: directed and random pixel streams against a frame tracker
module yellow_band_locator_tb import ybl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_PIXELS = 1000;
   localparam int LONG_LINE = 300;
   localparam int MAX_GAP = 17;
   localparam int CFG_ALL_ONES = (1 << CFG_W) - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_IMAGE_HEIGHT + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX = '1;
   localparam req_type YELLOW_PX = '{chan0: YELLOW_FULL, chan1: YELLOW_FULL, chan2: YELLOW_EMPTY};
   localparam req_type DARK_PX = '{chan0: 8'd0, chan1: 8'd0, chan2: 8'd255};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   // frame tracker state
   logic [CFG_W-1:0] cfg_width = CFG_W'(IMAGE_WIDTH_RESET);
   logic [CFG_W-1:0] cfg_height = CFG_W'(IMAGE_HEIGHT_RESET);
   logic [11:0]      col_pos, row_pos, best_row, run_from, row_run_from, best_col;
   logic [12:0]      row_count, best_count, run_len, row_run_len;

   rsp_type     expected_plates[$];
   int unsigned mismatches = 0;
   int unsigned plates_checked = 0;
   int unsigned pixels_sent = 0;
   int unsigned cycle_count = 0;
   bit          send_gaps = 1'b1;
   bit          take_stalls = 1'b1;

   yellow_band_locator dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("yellow_band_locator: mismatch");
      $finish;
   end

   function automatic int clamp_dim(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return int'(v);
   endfunction

   function automatic void clear_row();
      col_pos = '0;
      row_count = '0;
      run_len = '0;
      run_from = '0;
      row_run_len = '0;
      row_run_from = '0;
   endfunction

   function automatic void clear_frame();
      clear_row();
      row_pos = '0;
      best_count = '0;
      best_row = '0;
      best_col = '0;
   endfunction

   // advance the frame tracker by one pixel, queue a plate at the end of a frame
   function automatic void track_pixel(input req_type px);
      int      w;
      int      h;
      rsp_type plate;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      if (px.chan0 == YELLOW_FULL && px.chan1 == YELLOW_FULL && px.chan2 == YELLOW_EMPTY) begin
         if (run_len == 0) run_from = col_pos;
         run_len++;
         row_count++;
      end else begin
         if (run_len > row_run_len) begin
            row_run_len = run_len;
            row_run_from = run_from;
         end
         run_len = '0;
      end
      if (int'(col_pos) + 1 < w) begin
         col_pos++;
         return;
      end
      // row done, a run still open here never counts
      if (row_count > best_count) begin
         best_count = row_count;
         best_row = row_pos;
         best_col = row_run_from;
      end
      clear_row();
      if (int'(row_pos) + 1 < h) begin
         row_pos++;
         return;
      end
      plate.plate_x = best_col;
      plate.plate_y = best_row;
      expected_plates.push_back(plate);
      clear_frame();
   endfunction

   function automatic req_type draw_pixel(input int yellow_pct);
      logic [23:0] raw;
      int          flip;
      if ($urandom_range(0, 99) < yellow_pct) return YELLOW_PX;
      if ($urandom_range(0, 1) == 1) begin
         // yellow with one bit knocked out
         raw = YELLOW_PX;
         flip = $urandom_range(0, 23);
         raw[flip] = ~raw[flip];
      end else begin
         raw = 24'($urandom);
      end
      return req_type'(raw);
   endfunction

   function automatic int draw_dim(input int widest);
      if ($urandom_range(0, 9) == 0) return 0;
      return $urandom_range(1, ($urandom_range(0, 3) == 0) ? widest : 6);
   endfunction

   task automatic send_pixel(input req_type px);
      int gap;
      gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_ready !== 1'b1);
      pixels_sent++;
      track_pixel(px);
   endtask

   // Y yellow, a/b/c one byte off yellow, anything else dark
   task automatic send_pattern(input string pattern);
      req_type px;
      for (int i = 0; i < pattern.len(); i++) begin
         case (pattern[i])
            "Y": px = YELLOW_PX;
            "a": px = '{8'd255, 8'd255, 8'd1};
            "b": px = '{8'd254, 8'd255, 8'd0};
            "c": px = '{8'd255, 8'd0, 8'd0};
            default: px = DARK_PX;
         endcase
         send_pixel(px);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_plates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == CSR_IMAGE_WIDTH) cfg_width = CFG_W'(value);
      else if (index == CSR_IMAGE_HEIGHT) cfg_height = CFG_W'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      send_gaps = 1'b1;
      take_stalls = 1'b1;
      write_reg(CSR_IMAGE_WIDTH, 5);
      write_reg(CSR_IMAGE_HEIGHT, 2);
      // equal row counts keep the first row, open run at row end dropped
      send_pattern("DYDYYYYYba");
      // equal runs keep the first, empty first row
      send_pattern("DDDDcDYDYD");
      write_reg(CSR_IMAGE_HEIGHT, 1);
      // chosen row holds only an open run
      send_pattern("DDYYY");
      write_reg(CSR_IMAGE_WIDTH, 1);
      // no yellow anywhere
      send_pattern("a");
   endtask

   task automatic test_resize_mid_frame();
      write_reg(CSR_IMAGE_WIDTH, MAX_DIM_DEFAULT);
      write_reg(CSR_IMAGE_HEIGHT, MAX_DIM_DEFAULT);
      repeat (9) send_pixel(draw_pixel(60));
      // column now past the new last column, next word closes the row
      write_reg(CSR_IMAGE_WIDTH, 3);
      send_pattern("YDYY");
      write_reg(CSR_IMAGE_HEIGHT, 2);
      send_pattern("YDb");
   endtask

   task automatic test_largest_frames();
      // saturated width, a long row closed by shrinking the width
      write_reg(CSR_IMAGE_WIDTH, CFG_ALL_ONES);
      write_reg(CSR_IMAGE_HEIGHT, 0);
      for (int i = 0; i < LONG_LINE; i++)
         send_pixel((i == LONG_LINE - 2) ? YELLOW_PX : draw_pixel(0));
      write_reg(CSR_IMAGE_WIDTH, 3);
      send_pattern("D");
      // saturated height, a tall frame closed by shrinking the height
      write_reg(CSR_IMAGE_WIDTH, 0);
      write_reg(CSR_IMAGE_HEIGHT, CFG_ALL_ONES);
      for (int i = 0; i < LONG_LINE; i++)
         send_pixel((i == LONG_LINE - 1) ? YELLOW_PX : draw_pixel(0));
      write_reg(CSR_IMAGE_HEIGHT, 2);
      send_pattern("D");
   endtask

   task automatic test_random_frames();
      int unsigned start;
      int          pixels;
      int          pct;
      bit          resize;
      start = pixels_sent;
      resize = 1'b1;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         if (resize || $urandom_range(0, 2) == 0) begin
            if (resize || $urandom_range(0, 1) == 1) write_reg(CSR_IMAGE_WIDTH, draw_dim(40));
            if (resize || $urandom_range(0, 1) == 1) write_reg(CSR_IMAGE_HEIGHT, draw_dim(12));
         end
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX)),
                      $urandom_range(0, CFG_ALL_ONES));
         send_gaps = $urandom_range(0, 3) != 0;
         take_stalls = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 4))
            0: pct = 0;
            1: pct = 15;
            2: pct = 50;
            3: pct = 80;
            default: pct = 100;
         endcase
         pixels = clamp_dim(cfg_width) * clamp_dim(cfg_height);
         // now and then cut a frame short and resize in the middle of it
         resize = $urandom_range(0, 7) == 0;
         if (resize) pixels = $urandom_range(1, pixels);
         repeat (pixels) send_pixel(draw_pixel(pct));
      end
   endtask

   initial begin : plate_checker
      int      stall;
      rsp_type want;
      wait (!reset);
      forever begin
         stall = take_stalls ? $urandom_range(0, MAX_GAP) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_plates.size() == 0) begin
            mismatches++;
            $display("%0t: result word with none expected, plate_x=%0d plate_y=%0d",
                     $time, rsp_data.plate_x, rsp_data.plate_y);
         end else begin
            want = expected_plates.pop_front();
            if (rsp_data.plate_x !== want.plate_x) begin
               mismatches++;
               $display("%0t: plate_x expected %0d got %0d",
                        $time, want.plate_x, rsp_data.plate_x);
            end
            if (rsp_data.plate_y !== want.plate_y) begin
               mismatches++;
               $display("%0t: plate_y expected %0d got %0d",
                        $time, want.plate_y, rsp_data.plate_y);
            end
            plates_checked++;
         end
      end
   end

   initial begin
      clear_frame();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_resize_mid_frame();
      test_largest_frames();
      test_random_frames();
      wait_idle();
      $display("%0d pixels sent, %0d results checked in %0d cycles",
               pixels_sent, plates_checked, cycle_count);
      $display("sizes 1 to saturated each way, zero and oversize settings, resizes mid frame");
      if (mismatches == 0) begin
         $display("yellow_band_locator: match");
      end else begin
         $display("yellow_band_locator: mismatch");
      end
      $finish;
   end

endmodule

/* yellow_band_locator.f */
src/ybl_pkg.sv
src/ybl_scan.sv
src/yellow_band_locator.sv
bench/yellow_band_locator_tb.sv
